// ===== rtl/core/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and character codes for the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_MUL,
    TK_DIV,
    TK_ADD,
    TK_SUB,
    TK_END
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [3:0]  digit;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } term_op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_FINISH
  } back_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_FIX
  } md_state_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic done;
    logic zero_div;
  } md_resp_t;

endpackage

// ===== rtl/core/iee_front.sv =====
// ----------------------------------------------------------------------------
// iee_front
// Accepts characters, drops spaces and registers one classified token.
// ----------------------------------------------------------------------------
module iee_front
  import iee_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    char_code_i,
  input  queue_status_t q_status_i,
  output logic          push_o,
  output token_t        push_tok_o
);

  logic   tok_valid_q, tok_valid_d;
  token_t tok_q;
  token_t tok_d;
  logic   accept;
  logic   is_space;

  assign in_stall_o = tok_valid_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = tok_valid_q && !q_status_i.full;
  assign push_tok_o = tok_q;
  assign is_space   = (char_code_i == CH_SPACE);

  always_comb begin
    tok_d.digit = 4'(char_code_i - CH_ZERO);
    if (char_code_i >= CH_ZERO && char_code_i <= CH_NINE) begin
      tok_d.kind = TK_DIGIT;
    end else if (char_code_i == CH_STAR) begin
      tok_d.kind = TK_MUL;
    end else if (char_code_i == CH_SLASH) begin
      tok_d.kind = TK_DIV;
    end else if (char_code_i == CH_PLUS) begin
      tok_d.kind = TK_ADD;
    end else if (char_code_i == CH_MINUS) begin
      tok_d.kind = TK_SUB;
    end else begin
      tok_d.kind = TK_END;
    end
  end

  assign tok_valid_d = (tok_valid_q && !push_o) || (accept && !is_space);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q <= tok_d;
    end
  end

endmodule

// ===== rtl/core/iee_queue.sv =====
// ----------------------------------------------------------------------------
// iee_queue
// Small token queue between the front and the back.
// ----------------------------------------------------------------------------
module iee_queue
  import iee_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  token_t        push_tok_i,
  input  logic          pop_i,
  output token_t        pop_tok_o,
  output queue_status_t status_o
);

  token_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PTR_W:0]   count_q, count_d;

  assign status_o.full  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_tok_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

// ===== rtl/core/iee_muldiv.sv =====
// ----------------------------------------------------------------------------
// iee_muldiv
// Shared bit-serial unit: wrapping multiply and truncating signed divide.
// ----------------------------------------------------------------------------
module iee_muldiv
  import iee_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  md_req_t              req_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  output md_resp_t             resp_o,
  output logic [WORD_BITS-1:0] result_o
);

  localparam int unsigned CNT_W = $clog2(WORD_BITS);

  md_state_e            state_q, state_d;
  logic [WORD_BITS-1:0] a_q, a_d;
  logic [WORD_BITS-1:0] b_q, b_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic                 done_q, done_d;
  logic                 zero_q, zero_d;
  logic [WORD_BITS-1:0] res_q, res_d;
  logic [WORD_BITS-1:0] mul_sum;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS-1:0] abs_a, abs_b;

  assign resp_o.done     = done_q;
  assign resp_o.zero_div = zero_q;
  assign result_o        = res_q;

  assign abs_a   = a_i[WORD_BITS-1] ? '0 - a_i : a_i;
  assign abs_b   = b_i[WORD_BITS-1] ? '0 - b_i : b_i;
  assign mul_sum = acc_q + (b_q[0] ? a_q : '0);
  assign trial   = {acc_q, a_q[WORD_BITS-1]} - {1'b0, b_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          if (!req_i.is_div) begin
            state_d = MD_MUL;
          end else if (b_i != '0) begin
            state_d = MD_DIV;
          end
        end
      end
      MD_MUL: begin
        if (cnt_q == '0) begin
          state_d = MD_IDLE;
        end
      end
      MD_DIV: begin
        if (cnt_q == '0) begin
          state_d = MD_FIX;
        end
      end
      MD_FIX:  state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    res_d  = res_q;
    done_d = 1'b0;
    zero_d = zero_q;
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          acc_d  = '0;
          cnt_d  = CNT_W'(WORD_BITS - 1);
          zero_d = 1'b0;
          if (!req_i.is_div) begin
            a_d = a_i;
            b_d = b_i;
          end else if (b_i == '0) begin
            res_d  = '0;
            zero_d = 1'b1;
            done_d = 1'b1;
          end else begin
            a_d   = abs_a;
            b_d   = abs_b;
            neg_d = a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1];
          end
        end
      end
      MD_MUL: begin
        acc_d = mul_sum;
        a_d   = a_q << 1;
        b_d   = b_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          res_d  = mul_sum;
          done_d = 1'b1;
        end
      end
      MD_DIV: begin
        if (!trial[WORD_BITS]) begin
          acc_d = trial[WORD_BITS-1:0];
        end else begin
          acc_d = {acc_q[WORD_BITS-2:0], a_q[WORD_BITS-1]};
        end
        a_d   = {a_q[WORD_BITS-2:0], !trial[WORD_BITS]};
        cnt_d = cnt_q - 1'b1;
      end
      MD_FIX: begin
        res_d  = neg_q ? '0 - a_q : a_q;
        done_d = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    zero_q <= zero_d;
  end

endmodule

// ===== rtl/core/iee_back.sv =====
// ----------------------------------------------------------------------------
// iee_back
// Executes tokens: builds numbers, folds terms and sums, emits results.
// ----------------------------------------------------------------------------
module iee_back
  import iee_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  queue_status_t        q_status_i,
  input  token_t               pop_tok_i,
  output logic                 pop_o,
  output md_req_t              md_req_o,
  output logic [WORD_BITS-1:0] md_a_o,
  output logic [WORD_BITS-1:0] md_b_o,
  input  md_resp_t             md_resp_i,
  input  logic [WORD_BITS-1:0] md_result_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   value_o,
  output logic                 div_by_zero_o
);

  back_state_e          state_q, state_d;
  tok_kind_e            kind_q, kind_d;
  logic [WORD_BITS-1:0] num_q, num_d;
  logic [WORD_BITS-1:0] term_q, term_d;
  term_op_e             pend_q, pend_d;
  logic [WORD_BITS-1:0] sum_q, sum_d;
  logic                 minus_q, minus_d;
  logic                 dbz_q, dbz_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [31:0]   out_value_q, out_value_d;
  logic                 out_dbz_q, out_dbz_d;
  logic                 out_free;
  logic                 emit;
  logic [WORD_BITS-1:0] sum_res;
  logic [WORD_BITS-1:0] num_x10;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign pop_o         = (state_q == BK_IDLE) && !q_status_i.empty;
  assign emit          = (state_q == BK_FINISH) && (kind_q == TK_END) && out_free;
  assign sum_res       = minus_q ? sum_q - term_q : sum_q + term_q;
  assign num_x10       = (num_q << 3) + (num_q << 1);
  assign md_req_o.start  = pop_o && (pop_tok_i.kind != TK_DIGIT) && (pend_q != OP_NONE);
  assign md_req_o.is_div = (pend_q == OP_DIV);
  assign md_a_o        = term_q;
  assign md_b_o        = num_q;
  assign out_valid_o   = out_valid_q;
  assign value_o       = out_value_q;
  assign div_by_zero_o = out_dbz_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop_o && pop_tok_i.kind != TK_DIGIT) begin
          state_d = (pend_q != OP_NONE) ? BK_CALC : BK_FINISH;
        end
      end
      BK_CALC: begin
        if (md_resp_i.done) begin
          state_d = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (kind_q != TK_END || out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    kind_d      = kind_q;
    num_d       = num_q;
    term_d      = term_q;
    pend_d      = pend_q;
    sum_d       = sum_q;
    minus_d     = minus_q;
    dbz_d       = dbz_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_dbz_d   = out_dbz_q;
    case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          if (pop_tok_i.kind == TK_DIGIT) begin
            num_d = num_x10 + WORD_BITS'(pop_tok_i.digit);
          end else begin
            kind_d = pop_tok_i.kind;
            if (pend_q == OP_NONE) begin
              term_d = num_q;
            end
          end
        end
      end
      BK_CALC: begin
        if (md_resp_i.done) begin
          term_d = md_result_i;
          dbz_d  = dbz_q || md_resp_i.zero_div;
        end
      end
      BK_FINISH: begin
        case (kind_q)
          TK_MUL, TK_DIV: begin
            num_d  = '0;
            pend_d = (kind_q == TK_MUL) ? OP_MUL : OP_DIV;
          end
          TK_ADD, TK_SUB: begin
            num_d   = '0;
            pend_d  = OP_NONE;
            sum_d   = sum_res;
            term_d  = '0;
            minus_d = (kind_q == TK_SUB);
          end
          default: begin
            if (emit) begin
              num_d       = '0;
              term_d      = '0;
              pend_d      = OP_NONE;
              sum_d       = '0;
              minus_d     = 1'b0;
              dbz_d       = 1'b0;
              out_valid_d = 1'b1;
              out_value_d = 32'($signed(sum_res));
              out_dbz_d   = dbz_q;
            end
          end
        endcase
      end
      default: begin
        kind_d = kind_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      kind_q      <= TK_END;
      num_q       <= '0;
      term_q      <= '0;
      pend_q      <= OP_NONE;
      sum_q       <= '0;
      minus_q     <= 1'b0;
      dbz_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      num_q       <= num_d;
      term_q      <= term_d;
      pend_q      <= pend_d;
      sum_q       <= sum_d;
      minus_q     <= minus_d;
      dbz_q       <= dbz_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_dbz_q   <= out_dbz_d;
  end

endmodule

// ===== rtl/core/infix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Streaming integer infix evaluator with two precedence levels.
//
// Input channel: one ASCII character per request on char_code_i, taken when
// in_valid_i is high and in_stall_o is low. Spaces are dropped, digits build
// a number, * and / fold into a term, + and - fold terms into a sum; any
// other character ends the expression and produces one result request on
// value_o and div_by_zero_o (out_valid_o / out_stall_i).
// The back end pops no new token until it is done with the last. A digit is
// taken straight from the queue; any other character passes through a finish
// step, and one that closes a number after * or / first waits in a calc step
// for the shared multiply/divide unit, making one product or quotient bit
// per cycle, or ending without iterating for a zero divisor. A four-entry
// token queue lets the front keep taking characters while the back end
// computes.
// Reset clears the back end's accumulators, the queue and the output valid
// flag. While out_stall_i holds a result, the back end stops at the next
// terminator and the queue and front then fill up and raise in_stall_o.
// ----------------------------------------------------------------------------
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               div_by_zero_o
);

  queue_status_t        q_status;
  logic                 push;
  token_t               push_tok;
  logic                 pop;
  token_t               pop_tok;
  md_req_t              md_req;
  md_resp_t             md_resp;
  logic [WORD_BITS-1:0] md_a;
  logic [WORD_BITS-1:0] md_b;
  logic [WORD_BITS-1:0] md_result;

  iee_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_tok_o  (push_tok)
  );

  iee_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .pop_i      (pop),
    .pop_tok_o  (pop_tok),
    .status_o   (q_status)
  );

  iee_muldiv #(
    .WORD_BITS (WORD_BITS)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (md_req),
    .a_i      (md_a),
    .b_i      (md_b),
    .resp_o   (md_resp),
    .result_o (md_result)
  );

  iee_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .pop_tok_i     (pop_tok),
    .pop_o         (pop),
    .md_req_o      (md_req),
    .md_a_o        (md_a),
    .md_b_o        (md_b),
    .md_resp_i     (md_resp),
    .md_result_i   (md_result),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .div_by_zero_o (div_by_zero_o)
  );

endmodule

// ===== test/iee_checker.sv =====
// ----------------------------------------------------------------------------
// iee_checker
// Watches both channels of the infix expression evaluator, predicts the
// result of every expression from the accepted characters, and compares each
// accepted result field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module iee_checker
  import iee_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         char_code_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] value_i,
  input  logic               div_by_zero_i,
  output int                 mismatches_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 zero_div_results_o
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               div_by_zero;
  } eval_result_t;

  eval_result_t awaited_results[$];

  logic [31:0] number_q;
  logic [31:0] term_q;
  term_op_e    term_op_q;
  logic [31:0] sum_q;
  logic        minus_q;
  logic        zero_div_q;

  int mismatch_count = 0;
  int pending_count  = 0;
  int result_count   = 0;
  int zero_div_count = 0;

  assign mismatches_o       = mismatch_count;
  assign pending_o          = pending_count;
  assign results_o          = result_count;
  assign zero_div_results_o = zero_div_count;

  function automatic logic [31:0] trunc_quotient(input logic [31:0] num,
                                                 input logic [31:0] den,
                                                 output logic       zero_den);
    logic [31:0] mag_num;
    logic [31:0] mag_den;
    logic [31:0] quot;
    mag_num  = num[31] ? -num : num;
    mag_den  = den[31] ? -den : den;
    zero_den = (mag_den == 32'd0);
    quot     = zero_den ? 32'd0 : mag_num / mag_den;
    if (!zero_den && (num[31] ^ den[31])) quot = -quot;
    return quot;
  endfunction

  task automatic clear_eval();
    number_q   = '0;
    term_q     = '0;
    term_op_q  = OP_NONE;
    sum_q      = '0;
    minus_q    = 1'b0;
    zero_div_q = 1'b0;
  endtask

  task automatic fold_number();
    logic zero_den;
    case (term_op_q)
      OP_MUL: term_q = term_q * number_q;
      OP_DIV: begin
        term_q = trunc_quotient(term_q, number_q, zero_den);
        if (zero_den) zero_div_q = 1'b1;
      end
      default: term_q = number_q;
    endcase
    number_q  = '0;
    term_op_q = OP_NONE;
  endtask

  task automatic fold_term();
    fold_number();
    sum_q   = minus_q ? sum_q - term_q : sum_q + term_q;
    term_q  = '0;
    minus_q = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %0d (0x%08h), want %0d (0x%08h)", $realtime, what,
             $signed(got), got, $signed(want), want);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    eval_result_t got;
    eval_result_t want;
    if (!rst_ni) begin
      clear_eval();
      awaited_results.delete();
      pending_count = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{value: value_i, div_by_zero: div_by_zero_i};
        result_count++;
        if (div_by_zero_i) zero_div_count++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no request pending", got.value, 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (got.value !== want.value) report_mismatch("value", got.value, want.value);
          if (got.div_by_zero !== want.div_by_zero) begin
            report_mismatch("div_by_zero", {31'd0, got.div_by_zero},
                            {31'd0, want.div_by_zero});
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (char_code_i == CH_SPACE) begin
          // drop
        end else if (char_code_i >= CH_ZERO && char_code_i <= CH_NINE) begin
          number_q = number_q * 32'd10 + {24'd0, char_code_i - CH_ZERO};
        end else if (char_code_i == CH_STAR || char_code_i == CH_SLASH) begin
          fold_number();
          term_op_q = (char_code_i == CH_STAR) ? OP_MUL : OP_DIV;
        end else if (char_code_i == CH_PLUS || char_code_i == CH_MINUS) begin
          fold_term();
          minus_q = (char_code_i == CH_MINUS);
        end else begin
          fold_term();
          awaited_results.push_back('{value: sum_q, div_by_zero: zero_div_q});
          clear_eval();
        end
      end
      pending_count = awaited_results.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Character stream test for the infix expression evaluator: a few directed
// expressions on the edge cases, then random well-formed, broken and noise
// character sequences with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import iee_pkg::*;

  localparam int         ITEM_TARGET  = 1650;
  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         DRAIN_CYCLES = 48;
  localparam logic [7:0] CH_EQUALS    = 8'h3D;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic [7:0]         char_code   = 8'h00;
  logic               out_stall   = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic signed [31:0] value;
  logic               div_by_zero;

  int mismatches;
  int pending;
  int results;
  int zero_divs;

  int chars_sent  = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;

  logic [7:0] op_chars [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

  infix_expression_evaluator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .char_code_i   (char_code),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .value_o       (value),
    .div_by_zero_o (div_by_zero)
  );

  iee_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .char_code_i        (char_code),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .value_i            (value),
    .div_by_zero_i      (div_by_zero),
    .mismatches_o       (mismatches),
    .pending_o          (pending),
    .results_o          (results),
    .zero_div_results_o (zero_divs)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still pending", cycle_count, pending);
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_char(input logic [7:0] code);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(text[i]);
  endtask

  task automatic maybe_space();
    if ($urandom_range(0, 3) == 0) send_char(CH_SPACE);
  endtask

  function automatic logic [7:0] end_char();
    logic [7:0] code;
    do begin
      code = 8'($urandom_range(0, 255));
    end while (code == CH_SPACE || (code >= CH_ZERO && code <= CH_NINE) ||
               code == CH_PLUS || code == CH_MINUS || code == CH_STAR || code == CH_SLASH);
    return code;
  endfunction

  task automatic send_expression();
    int         terms;
    int         ndigits;
    logic [7:0] op;
    terms = $urandom_range(1, 6);
    op    = CH_PLUS;
    if ($urandom_range(0, 7) == 0) send_char(CH_MINUS);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) begin
        op = op_chars[$urandom_range(0, 3)];
        maybe_space();
        send_char(op);
        maybe_space();
      end
      if (op == CH_SLASH && $urandom_range(0, 5) == 0) begin
        send_char(CH_ZERO);
      end else begin
        ndigits = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 3);
        repeat (ndigits) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
      end
    end
    maybe_space();
    send_char(end_char());
  endtask

  initial begin
    int         pick;
    int         k;
    logic [7:0] code;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // most negative by minus one, widest numbers
    send_text("2147483648/4294967295=");
    // empty leading number, zero divisor, a space
    send_text("-60/0 +9*3");
    send_char(8'hFF);
    // empty number before multiply
    send_text("*7");
    send_char(8'h00);

    while (chars_sent < ITEM_TARGET) begin
      if (chars_sent >= ITEM_TARGET * 85 / 100) calm = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        repeat ($urandom_range(1, 10)) begin
          k = $urandom_range(0, 14);
          if (k < 10) code = CH_ZERO + 8'(k);
          else if (k == 10) code = CH_SPACE;
          else code = op_chars[k - 11];
          send_char(code);
        end
        send_char(end_char());
      end else begin
        send_expression();
      end
    end
    // flush any partial expression left by noise
    send_char(CH_EQUALS);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters; checked %0d expression results, %0d with a zero divisor.",
             chars_sent, results, zero_divs);
    $display("Directed edge cases, then random well-formed, broken and noise sequences.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
